FILE: src/lifn_pkg.sv
// ----------------------------------------------------------------------------
// lifn_pkg
// shared types and constants for the integrate-and-fire neuron with a
// delayed synaptic event queue
// ----------------------------------------------------------------------------
package lifn_pkg;

   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int SYNAPSE_COUNT_DEF = 256;

   localparam int MEM_W   = 32;
   localparam int LEAK_W  = 17;
   localparam int REFR_W  = 16;
   localparam int TIME_W  = 32;
   localparam int IDX_W   = 8;
   localparam int WGT_W   = 24;
   localparam int DLY_W   = 16;
   localparam int CMD_W   = 2;
   localparam int LEAK_SH = 16;
   localparam int MUL_W   = MEM_W + LEAK_W;

   localparam int REQ_DW  = 80;
   localparam int RSP_DW  = 40;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 32;

   localparam logic [CSR_AW-1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_LEAK       = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_REFRACTORY = 2'd2;

   localparam logic signed [MEM_W-1:0] LEAK_RESET = 32'sd65536;
   localparam logic [REFR_W-1:0]       REFR_RESET = 16'd100;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK,
      CMD_SPIKE,
      CMD_LOAD,
      CMD_REINIT
   } cmd_type;

   typedef enum logic {
      ALU_ADD,
      ALU_MUL
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_SCAN,
      ST_TICK_SAT,
      ST_TICK_FIRE,
      ST_TICK_MUL,
      ST_TICK_LEAK,
      ST_SPK_RD,
      ST_SPK_ADD,
      ST_SPK_FIND,
      ST_DONE
   } state_type;

endpackage

FILE: src/lifn_ram.sv
// ----------------------------------------------------------------------------
// lifn_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module lifn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/lifn_alu.sv
// ----------------------------------------------------------------------------
// lifn_alu
// shared arithmetic unit: signed accumulate add or membrane by leak multiply
// ----------------------------------------------------------------------------
module lifn_alu #(
   parameter int ACC_W = 37
) (
   input  lifn_pkg::alu_op_type              op,
   input  logic signed [ACC_W-1:0]           opa,
   input  logic signed [ACC_W-1:0]           opb,
   output logic [lifn_pkg::MUL_W-1:0]        y
);

   import lifn_pkg::*;

   logic signed [ACC_W-1:0] sum;

   assign sum = opa + opb;

   always_comb begin
      case (op)
         ALU_ADD: y = MUL_W'(sum);
         ALU_MUL: y = MUL_W'(opa[MEM_W-1:0]) * MUL_W'(opb[LEAK_W-1:0]);
         default: y = '0;
      endcase
   end

endmodule

FILE: src/lif_neuron_with_delayed_synapse_queue_unit.sv
// ----------------------------------------------------------------------------
// lif_neuron_with_delayed_synapse_queue_unit
// leaky integrate-and-fire neuron with a table of synapses and a queue of
// delayed synaptic events, driven by a small sequencer around one shared ALU
// ----------------------------------------------------------------------------
// One request is taken at a time and each gives one response. In a tick
// the event queue memory is read one entry per cycle and each due weight
// goes through the shared adder, then saturation and the threshold test
// follow, and one leak multiply when it does not fire. A spike with a valid
// index does a synapse table read, one add for the arrival time, then a search
// of the valid bits for a free slot, one per cycle. A synapse load or a reinit
// goes straight to the response. The response register frees the sequencer as
// soon as it captures the response.
// ----------------------------------------------------------------------------
module lif_neuron_with_delayed_synapse_queue_unit #(
   parameter int QUEUE_DEPTH   = lifn_pkg::QUEUE_DEPTH_DEF,
   parameter int SYNAPSE_COUNT = lifn_pkg::SYNAPSE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lifn_pkg::REQ_DW-1:0]   req_tdata,   // time_req, synapse_index, weight, delay
   input  logic [lifn_pkg::CMD_W-1:0]    req_tuser,   // command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lifn_pkg::RSP_DW-1:0]   rsp_tdata,   // spike_fired, membrane, event_dropped
   input  logic                          csr_we,
   input  logic [lifn_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [lifn_pkg::CSR_DW-1:0]   csr_wdata
);

   import lifn_pkg::*;

   localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = QW + 1;
   localparam int SW    = (SYNAPSE_COUNT > 1) ? $clog2(SYNAPSE_COUNT) : 1;
   localparam int ACC_W = MEM_W + $clog2(QUEUE_DEPTH + 1);
   localparam int QE_W  = TIME_W + WGT_W;
   localparam int SE_W  = WGT_W + DLY_W;
   localparam logic [CW-1:0] Q_LAST = CW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] Q_END  = CW'(QUEUE_DEPTH);
   localparam logic signed [MEM_W-1:0] MEM_MAX = {1'b0, {(MEM_W-1){1'b1}}};
   localparam logic signed [MEM_W-1:0] MEM_MIN = {1'b1, {(MEM_W-1){1'b0}}};

   // request fields
   cmd_type                   req_cmd;
   logic [TIME_W-1:0]         req_time;
   logic [IDX_W-1:0]          req_idx;
   logic [WGT_W-1:0]          req_wgt;
   logic [DLY_W-1:0]          req_dly;
   logic                      req_idx_ok;
   logic                      accept;

   assign req_cmd    = cmd_type'(req_tuser);
   assign req_time   = req_tdata[TIME_W-1:0];
   assign req_idx    = req_tdata[TIME_W +: IDX_W];
   assign req_wgt    = req_tdata[TIME_W+IDX_W +: WGT_W];
   assign req_dly    = req_tdata[TIME_W+IDX_W+WGT_W +: DLY_W];
   assign req_idx_ok = (32'(req_idx) < 32'(SYNAPSE_COUNT));

   // registers
   state_type                 state_ff, state_in;
   logic signed [MEM_W-1:0]   thr_ff, thr_in;
   logic [LEAK_W-1:0]         leak_ff, leak_in;
   logic [REFR_W-1:0]         refr_ff, refr_in;
   logic signed [MEM_W-1:0]   mem_ff, mem_in;
   logic [TIME_W-1:0]         last_ff, last_in;
   logic                      has_fired_ff, has_fired_in;
   logic [QUEUE_DEPTH-1:0]    valid_ff, valid_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      pend_ff, pend_in;
   logic                      out_valid_ff, out_valid_in;

   logic [TIME_W-1:0]         time_ff, time_in;
   logic [SW-1:0]             idx_ff, idx_in;
   logic [QW-1:0]             pidx_ff, pidx_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [MUL_W-1:0]          prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic [TIME_W-1:0]         arr_ff, arr_in;
   logic [WGT_W-1:0]          wt_ff, wt_in;
   logic                      fire_ff, fire_in;
   logic                      drop_ff, drop_in;
   logic                      out_fire_ff, out_fire_in;
   logic signed [MEM_W-1:0]   out_mem_ff, out_mem_in;
   logic                      out_drop_ff, out_drop_in;

   // memories and shared unit
   logic                      syn_we;
   logic [SW-1:0]             syn_waddr;
   logic [SE_W-1:0]           syn_wdata;
   logic [SE_W-1:0]           syn_rdata;
   logic                      q_we;
   logic [QW-1:0]             q_waddr;
   logic [QE_W-1:0]           q_wdata;
   logic [QW-1:0]             q_raddr;
   logic [QE_W-1:0]           q_rdata;
   alu_op_type                alu_op;
   logic signed [ACC_W-1:0]   alu_a;
   logic signed [ACC_W-1:0]   alu_b;
   logic [MUL_W-1:0]          alu_y;

   // datapath helpers
   logic [TIME_W-1:0]         q_arr;
   logic [WGT_W-1:0]          q_wgt;
   logic [WGT_W-1:0]          syn_wgt;
   logic [DLY_W-1:0]          syn_dly;
   logic                      hit;
   logic [ACC_W-MEM_W:0]      acc_hi;
   logic signed [MEM_W-1:0]   acc_sat;
   logic                      refractory;
   logic                      fire_now;
   logic [MEM_W-1:0]          mem_u;
   logic [MEM_W-1:0]          mem_mag;
   logic [MEM_W:0]            sh;
   logic signed [MEM_W-1:0]   leak_res;
   logic                      free_slot;
   logic [TIME_W-1:0]         spike_arr;
   logic                      out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   lifn_ram #(
      .WIDTH (SE_W),
      .DEPTH (SYNAPSE_COUNT)
   ) u_syn_ram (
      .clock (clock),
      .we    (syn_we),
      .waddr (syn_waddr),
      .wdata (syn_wdata),
      .raddr (idx_ff),
      .rdata (syn_rdata)
   );

   lifn_ram #(
      .WIDTH (QE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   lifn_alu #(
      .ACC_W (ACC_W)
   ) u_alu (
      .op  (alu_op),
      .opa (alu_a),
      .opb (alu_b),
      .y   (alu_y)
   );

   assign q_arr   = q_rdata[TIME_W-1:0];
   assign q_wgt   = q_rdata[TIME_W +: WGT_W];
   assign syn_wgt = syn_rdata[WGT_W-1:0];
   assign syn_dly = syn_rdata[WGT_W +: DLY_W];

   assign hit = pend_ff && valid_ff[pidx_ff] && (q_arr <= time_ff);

   assign acc_hi  = acc_ff[ACC_W-1:MEM_W-1];
   assign acc_sat = ((&acc_hi) || !(|acc_hi)) ? acc_ff[MEM_W-1:0] :
                    (acc_ff[ACC_W-1] ? MEM_MIN : MEM_MAX);

   assign refractory = has_fired_ff && ((time_ff - last_ff) < TIME_W'(refr_ff));
   assign fire_now   = (mem_ff > thr_ff);

   assign mem_u   = mem_ff;
   assign mem_mag = mem_u[MEM_W-1] ? (~mem_u + MEM_W'(1)) : mem_u;

   // magnitude times leak, scaled back, sign restored and saturated
   assign sh = prod_ff[LEAK_SH +: MEM_W+1];
   always_comb begin
      if (!neg_ff) begin
         leak_res = (sh[MEM_W] || sh[MEM_W-1]) ? MEM_MAX : sh[MEM_W-1:0];
      end else if (sh[MEM_W] || (sh[MEM_W-1] && (|sh[MEM_W-2:0]))) begin
         leak_res = MEM_MIN;
      end else begin
         leak_res = ~sh[MEM_W-1:0] + MEM_W'(1);
      end
   end

   assign free_slot = !valid_ff[cnt_ff[QW-1:0]];
   assign spike_arr = alu_y[TIME_W] ? '1 : alu_y[TIME_W-1:0];
   assign out_free  = !out_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_TICK:  state_in = ST_TICK_SCAN;
                  CMD_SPIKE: state_in = req_idx_ok ? ST_SPK_RD : ST_DONE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_TICK_SCAN: begin
            if (cnt_ff == Q_END) begin
               state_in = ST_TICK_SAT;
            end
         end
         ST_TICK_SAT:  state_in = ST_TICK_FIRE;
         ST_TICK_FIRE: state_in = fire_now ? ST_DONE : ST_TICK_MUL;
         ST_TICK_MUL:  state_in = ST_TICK_LEAK;
         ST_TICK_LEAK: state_in = ST_DONE;
         ST_SPK_RD:    state_in = ST_SPK_ADD;
         ST_SPK_ADD:   state_in = ST_SPK_FIND;
         ST_SPK_FIND: begin
            if (free_slot || (cnt_ff == Q_LAST)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      alu_op    = ALU_ADD;
      alu_a     = acc_ff;
      alu_b     = {{(ACC_W-WGT_W){q_wgt[WGT_W-1]}}, q_wgt};
      syn_we    = 1'b0;
      syn_waddr = SW'(req_idx);
      syn_wdata = {req_dly, req_wgt};
      q_we      = 1'b0;
      q_waddr   = cnt_ff[QW-1:0];
      q_wdata   = {wt_ff, arr_ff};
      q_raddr   = cnt_ff[QW-1:0];
      case (state_ff)
         ST_IDLE: begin
            syn_we = accept && (req_cmd == CMD_LOAD) && req_idx_ok;
         end
         ST_SPK_ADD: begin
            alu_a = ACC_W'(time_ff);
            alu_b = ACC_W'(syn_dly);
         end
         ST_SPK_FIND: begin
            q_we = free_slot;
         end
         ST_TICK_MUL: begin
            alu_op = ALU_MUL;
            alu_a  = ACC_W'(mem_mag);
            alu_b  = ACC_W'(leak_ff);
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      thr_in       = thr_ff;
      leak_in      = leak_ff;
      refr_in      = refr_ff;
      mem_in       = mem_ff;
      last_in      = last_ff;
      has_fired_in = has_fired_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      time_in      = time_ff;
      idx_in       = idx_ff;
      pidx_in      = pidx_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      arr_in       = arr_ff;
      wt_in        = wt_ff;
      fire_in      = fire_ff;
      drop_in      = drop_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_fire_in  = out_fire_ff;
      out_mem_in   = out_mem_ff;
      out_drop_in  = out_drop_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_THRESHOLD:  thr_in  = csr_wdata;
            CSR_LEAK:       leak_in = csr_wdata[LEAK_W-1:0];
            CSR_REFRACTORY: refr_in = csr_wdata[REFR_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               time_in = req_time;
               idx_in  = SW'(req_idx);
               fire_in = 1'b0;
               drop_in = 1'b0;
               cnt_in  = '0;
               pend_in = 1'b0;
               acc_in  = ACC_W'(mem_ff);
               if (req_cmd == CMD_REINIT) begin
                  valid_in = '0;
                  mem_in   = '0;
               end
            end
         end
         ST_TICK_SCAN: begin
            // read of the next entry overlaps the test of the previous one
            if (cnt_ff < Q_END) begin
               cnt_in  = cnt_ff + CW'(1);
               pend_in = 1'b1;
               pidx_in = cnt_ff[QW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (hit) begin
               acc_in            = alu_y[ACC_W-1:0];
               valid_in[pidx_ff] = 1'b0;
            end
         end
         ST_TICK_SAT: begin
            mem_in = refractory ? '0 : acc_sat;
         end
         ST_TICK_FIRE: begin
            neg_in = mem_ff[MEM_W-1];
            if (fire_now) begin
               fire_in      = 1'b1;
               mem_in       = '0;
               last_in      = time_ff;
               has_fired_in = 1'b1;
            end
         end
         ST_TICK_MUL: begin
            prod_in = alu_y;
         end
         ST_TICK_LEAK: begin
            mem_in = leak_res;
         end
         ST_SPK_ADD: begin
            arr_in = spike_arr;
            wt_in  = syn_wgt;
         end
         ST_SPK_FIND: begin
            if (free_slot) begin
               valid_in[cnt_ff[QW-1:0]] = 1'b1;
            end else if (cnt_ff == Q_LAST) begin
               drop_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_fire_in  = fire_ff;
               out_mem_in   = mem_ff;
               out_drop_in  = drop_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= '0;
         leak_ff      <= LEAK_RESET[LEAK_W-1:0];
         refr_ff      <= REFR_RESET;
         mem_ff       <= '0;
         last_ff      <= '0;
         has_fired_ff <= 1'b0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         leak_ff      <= leak_in;
         refr_ff      <= refr_in;
         mem_ff       <= mem_in;
         last_ff      <= last_in;
         has_fired_ff <= has_fired_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff     <= time_in;
      idx_ff      <= idx_in;
      pidx_ff     <= pidx_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      arr_ff      <= arr_in;
      wt_ff       <= wt_in;
      fire_ff     <= fire_in;
      drop_ff     <= drop_in;
      out_fire_ff <= out_fire_in;
      out_mem_ff  <= out_mem_in;
      out_drop_ff <= out_drop_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-MEM_W-2){1'b0}}, out_drop_ff, out_mem_ff, out_fire_ff};

   a_fire_drop_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_fire_ff && out_drop_ff))
      else $error("fire and drop flagged on one response");

   a_fire_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_fire_ff) |-> (out_mem_ff == '0))
      else $error("membrane not zero after firing");

   a_reinit_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_REINIT)) |=> (valid_ff == '0))
      else $error("queue not empty after reinit");

   a_fire_record: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_TICK_FIRE) && fire_now) |=>
         (has_fired_ff && (last_ff == $past(time_ff))))
      else $error("fire time not recorded");

endmodule
